[rtl/ddwsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddwsp_pkg
// Shared constants and register codes for the differential-drive wheel speed
// PID controller.
// ----------------------------------------------------------------------------
package ddwsp_pkg;

    localparam int TICK_BITS_DEF = 10;
    localparam int GAIN_W        = 16;
    localparam int CMD_W         = 9;
    localparam int MAG_W         = 10;
    localparam int DRIVE_W       = 8;
    localparam int INTEG_W       = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 2'd2;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 16'd256;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 16'd0;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 16'd0;

    localparam int DRIVE_MIN_I = 40;
    localparam int DRIVE_MAX_I = 250;
    localparam int INTEG_MAX_I = 255;

    localparam logic [DRIVE_W-1:0] DRIVE_MIN  = DRIVE_W'(DRIVE_MIN_I);
    localparam logic [DRIVE_W-1:0] DRIVE_MAX  = DRIVE_W'(DRIVE_MAX_I);
    localparam logic [INTEG_W-1:0] INTEG_TOP  = INTEG_W'(INTEG_MAX_I * 256);
    localparam logic [INTEG_W-1:0] DRIVE_LO_Q = INTEG_W'(DRIVE_MIN_I * 256);
    localparam logic [INTEG_W-1:0] DRIVE_HI_Q = INTEG_W'((DRIVE_MAX_I + 1) * 256);

endpackage

[rtl/ddwsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddwsp_if
// Valid/ready channels of the wheel speed PID: command beats, drive beats
// and gain register writes.
// ----------------------------------------------------------------------------
interface ddwsp_in_if #(
    parameter int TICK_BITS = ddwsp_pkg::TICK_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic signed [ddwsp_pkg::CMD_W-1:0]  cmd_speed;
    logic signed [ddwsp_pkg::CMD_W-1:0]  cmd_turn;
    logic        [TICK_BITS-1:0]         ticks_left;
    logic        [TICK_BITS-1:0]         ticks_right;

    modport source (output valid, cmd_speed, cmd_turn, ticks_left, ticks_right,
                    input ready);
    modport sink   (input valid, cmd_speed, cmd_turn, ticks_left, ticks_right,
                    output ready);
endinterface

interface ddwsp_out_if;
    logic                               valid;
    logic                               ready;
    logic [ddwsp_pkg::DRIVE_W-1:0]      drive_left;
    logic [ddwsp_pkg::DRIVE_W-1:0]      drive_right;
    logic                               reverse_left;
    logic                               reverse_right;

    modport source (output valid, drive_left, drive_right, reverse_left, reverse_right,
                    input ready);
    modport sink   (input valid, drive_left, drive_right, reverse_left, reverse_right,
                    output ready);
endinterface

interface ddwsp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ddwsp_pkg::CFG_IDX_W-1:0]    index;
    logic [ddwsp_pkg::GAIN_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/diff_drive_wheel_speed_pid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_wheel_speed_pid
// Two-wheel speed controller: per wheel PID with clamped integral and
// derivative on measurement, drive clamped to 40..250.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg  : gain writes (0 prop, 1 integ, 2 deriv, unsigned Q8.8); always
//            ready, write only while no command beat is in flight.
//   i_in   : one command beat per control cycle: speed, turn and the tick
//            counts of both wheels.
//   o_res  : one drive beat per command beat: drive levels and directions.
// Timing: a command beat passes the input register, then the result register,
//   before its drive beat is valid; a held result can keep it waiting in the
//   input register. Throughput: one beat per cycle while o_res.ready holds; the
//   PID arithmetic between the two registers (three 16-bit gain multiplies
//   per wheel and the integral clamp feeding the sum) sets the clock.
// Reset: gains go to prop 1.0, integ 0, deriv 0; integrals, last ticks and
//   directions clear; both stages empty.
// Stall: a held result keeps the input register full; one more beat is taken
//   while the result waits, then i_in.ready drops until o_res.ready returns.
// ----------------------------------------------------------------------------
module diff_drive_wheel_speed_pid #(
    parameter int TICK_BITS = ddwsp_pkg::TICK_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ddwsp_cfg_if.sink       i_cfg,
    ddwsp_in_if.sink        i_in,
    ddwsp_out_if.source     o_res
);
    import ddwsp_pkg::*;

    localparam int BW = (TICK_BITS > MAG_W) ? TICK_BITS : MAG_W;
    localparam int EW = BW + 1;
    localparam int CW = TICK_BITS + 1;
    localparam int PW = EW + GAIN_W + 1;
    localparam int SW = PW + 2;

    logic [GAIN_W-1:0]          r_kp, r_ki, r_kd;

    logic                       r_s1_vld;
    logic signed [CMD_W-1:0]    r_speed, r_turn;
    logic [TICK_BITS-1:0]       r_ticks [2];

    logic [INTEG_W-1:0]         r_integ [2];
    logic [TICK_BITS-1:0]       r_last  [2];
    logic                       r_back  [2];

    logic                       r_out_vld;
    logic [DRIVE_W-1:0]         r_drive [2];

    logic                       adv;
    logic                       in_acc;

    logic signed [MAG_W-1:0]    c_target [2];
    logic [MAG_W-1:0]           c_mag    [2];
    logic                       n_back   [2];
    logic signed [EW-1:0]       c_err    [2];
    logic signed [CW-1:0]       c_chg    [2];
    logic signed [PW-1:0]       c_prop   [2];
    logic signed [PW-1:0]       c_int    [2];
    logic signed [PW-1:0]       c_der    [2];
    logic signed [SW-1:0]       c_ni     [2];
    logic [INTEG_W-1:0]         n_integ  [2];
    logic signed [SW-1:0]       c_sum    [2];
    logic [DRIVE_W-1:0]         n_drive  [2];

    assign adv         = r_s1_vld && (!r_out_vld || o_res.ready);
    assign i_in.ready  = !r_s1_vld || adv;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // gain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= PROP_GAIN_RST;
            r_ki <= INTEG_GAIN_RST;
            r_kd <= DERIV_GAIN_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PROP_GAIN:  r_kp <= i_cfg.data;
                CFG_INTEG_GAIN: r_ki <= i_cfg.data;
                CFG_DERIV_GAIN: r_kd <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_speed    <= i_in.cmd_speed;
            r_turn     <= i_in.cmd_turn;
            r_ticks[0] <= i_in.ticks_left;
            r_ticks[1] <= i_in.ticks_right;
        end
    end

    // per wheel PID
    always_comb begin
        c_target[0] = MAG_W'($signed({r_speed[CMD_W-1], r_speed})
                      + $signed({r_turn[CMD_W-1], r_turn}));
        c_target[1] = MAG_W'($signed({r_speed[CMD_W-1], r_speed})
                      - $signed({r_turn[CMD_W-1], r_turn}));
        for (int w = 0; w < 2; w++) begin
            if (c_target[w][MAG_W-1]) begin
                n_back[w] = 1'b1;
                c_mag[w]  = MAG_W'(-c_target[w]);
            end else begin
                n_back[w] = (c_target[w] == '0) ? r_back[w] : 1'b0;
                c_mag[w]  = MAG_W'(c_target[w]);
            end

            c_err[w] = $signed({{(EW-MAG_W){1'b0}}, c_mag[w]})
                     - $signed({{(EW-TICK_BITS){1'b0}}, r_ticks[w]});
            c_chg[w] = $signed({1'b0, r_ticks[w]}) - $signed({1'b0, r_last[w]});

            c_prop[w] = $signed({1'b0, r_kp}) * c_err[w];
            c_int[w]  = $signed({1'b0, r_ki}) * c_err[w];
            c_der[w]  = $signed({1'b0, r_kd}) * c_chg[w];

            c_ni[w] = $signed({{(SW-PW){c_int[w][PW-1]}}, c_int[w]})
                    + $signed({{(SW-INTEG_W){1'b0}}, r_integ[w]});
            if (c_ni[w][SW-1]) begin
                n_integ[w] = '0;
            end else if (c_ni[w] > $signed({{(SW-INTEG_W){1'b0}}, INTEG_TOP})) begin
                n_integ[w] = INTEG_TOP;
            end else begin
                n_integ[w] = c_ni[w][INTEG_W-1:0];
            end

            c_sum[w] = $signed({{(SW-PW){c_prop[w][PW-1]}}, c_prop[w]})
                     + $signed({{(SW-INTEG_W){1'b0}}, n_integ[w]})
                     - $signed({{(SW-PW){c_der[w][PW-1]}}, c_der[w]});
            if (c_sum[w] < $signed({{(SW-INTEG_W){1'b0}}, DRIVE_LO_Q})) begin
                n_drive[w] = DRIVE_MIN;
            end else if (c_sum[w] >= $signed({{(SW-INTEG_W){1'b0}}, DRIVE_HI_Q})) begin
                n_drive[w] = DRIVE_MAX;
            end else begin
                n_drive[w] = c_sum[w][INTEG_W-1:INTEG_W-DRIVE_W];
            end
        end
    end

    // wheel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < 2; w++) begin
                r_integ[w] <= '0;
                r_last[w]  <= '0;
                r_back[w]  <= 1'b0;
            end
        end else if (adv) begin
            for (int w = 0; w < 2; w++) begin
                r_integ[w] <= n_integ[w];
                r_last[w]  <= r_ticks[w];
                r_back[w]  <= n_back[w];
            end
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_drive[0] <= n_drive[0];
            r_drive[1] <= n_drive[1];
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.drive_left    = r_drive[0];
    assign o_res.drive_right   = r_drive[1];
    assign o_res.reverse_left  = r_back[0];
    assign o_res.reverse_right = r_back[1];

endmodule
